### hdl/bstt_pkg.sv
package bstt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 4096;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned SCORE_W = 21;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned BOUND_W = 2;

   localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic [DEPTH_W-1:0]        depth;
      logic [BOUND_W-1:0]        bound;
      logic signed [SCORE_W-1:0] score;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DECIDE,
      ST_WIPE
   } state_type;

endpackage

### hdl/bstt_slot_reduce.sv
module bstt_slot_reduce
   import bstt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [KEY_W-1:0]                  key,
   output logic                              done,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  slot
);

   localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
   localparam bit          IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));

   logic done_ff;

   assign done = done_ff;

   generate
      if (IS_POW2) begin : g_mask
         logic [IDX_W-1:0] slot_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               slot_ff <= key[IDX_W-1:0];
            end
         end

         assign slot = slot_ff;
      end else begin : g_digit
         localparam int unsigned DIGIT_W = 4;
         localparam int unsigned STEPS   = KEY_W / DIGIT_W;
         localparam int unsigned CNT_W   = $clog2(STEPS);
         localparam int unsigned TRIAL_W = IDX_W + DIGIT_W;
         localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

         logic [KEY_W-1:0]   key_ff;
         logic [IDX_W-1:0]   rem_ff;
         logic [CNT_W-1:0]   cnt_ff;
         logic               run_ff;
         logic [TRIAL_W-1:0] trial;
         logic [IDX_W-1:0]   rem_in;

         // one key nibble a cycle, msb first: rem = (16*rem + nibble) mod n
         // the quotient digit comes from comparing against all fifteen multiples at once
         always_comb begin
            trial  = {rem_ff, key_ff[KEY_W-1 -: DIGIT_W]};
            rem_in = trial[IDX_W-1:0];
            for (int k = 1; k < (1 << DIGIT_W); k++) begin
               if (trial >= TRIAL_W'(k * TABLE_ENTRIES)) begin
                  rem_in = IDX_W'(trial - TRIAL_W'(k * TABLE_ENTRIES));
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= run_ff && !start && (cnt_ff == LAST_STEP);
               if (start) begin
                  run_ff <= 1'b1;
                  cnt_ff <= '0;
               end else if (run_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == LAST_STEP) begin
                     run_ff <= 1'b0;
                  end
               end
            end
            if (start) begin
               key_ff <= key;
               rem_ff <= '0;
            end else if (run_ff) begin
               key_ff <= {key_ff[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               rem_ff <= rem_in;
            end
         end

         assign slot = rem_ff;
      end
   endgenerate

endmodule

### hdl/bounded_score_transposition_table_unit.sv
// direct-mapped transposition table for alpha-beta search
// request channel: req_command with key, depth, window, score and bound kind,
// taken at a rising edge where start is high and busy is low
// result channel: rsp_hit and rsp_score shown for one cycle with rsp_valid high,
// exactly one result per request; the receiver cannot stall it
// the entry is the key modulo the table size; with a power-of-two size that is
// the low key bits and ready the cycle after the request
// otherwise a remainder unit takes four key bits a cycle, most significant first
// probe: read address issued, then compare on the registered memory word,
// and the result is registered from that compare
// record: one write, with the result registered at the same edge as the write
// clear: one entry written per cycle, result registered with the write of the last entry
// unused command: miss result the next cycle
// busy is high from the request edge until the result is shown, but an unused command
// leaves it low; one request is in flight at a time, and the single memory port pair
// sets this figure; reset starts the same clearing pass with busy high,
// and gives no result
module bounded_score_transposition_table_unit
   import bstt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [KEY_W-1:0]          req_position_key,
   input  logic [DEPTH_W-1:0]        req_search_depth,
   input  logic signed [SCORE_W-1:0] req_alpha_bound,
   input  logic signed [SCORE_W-1:0] req_beta_bound,
   input  logic signed [SCORE_W-1:0] req_new_score,
   input  logic [BOUND_W-1:0]        req_new_bound_kind,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [SCORE_W-1:0] rsp_score
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]          cmd_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [DEPTH_W-1:0]        depth_ff;
   logic signed [SCORE_W-1:0] alpha_ff;
   logic signed [SCORE_W-1:0] beta_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [BOUND_W-1:0]        kind_ff;

   logic [IDX_W-1:0] wipe_ff, wipe_in;
   logic             wipe_rsp_ff, wipe_rsp_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic             accept;
   logic             reduce_start;
   logic             reduce_done;
   logic [IDX_W-1:0] slot;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;

   logic                      probe_hit;
   logic signed [SCORE_W-1:0] probe_score;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign reduce_start = accept && (req_command == CMD_PROBE || req_command == CMD_RECORD);

   bstt_slot_reduce #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_reduce (
      .clock(clock),
      .reset(reset),
      .start(reduce_start),
      .key(req_position_key),
      .done(reduce_done),
      .slot(slot)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         key_ff   <= req_position_key;
         depth_ff <= req_search_depth;
         alpha_ff <= req_alpha_bound;
         beta_ff  <= req_beta_bound;
         score_ff <= req_new_score;
         kind_ff  <= req_new_bound_kind;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_score_ff <= rsp_score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         wipe_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         wipe_rsp_ff  <= wipe_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hit test on the word read back from the table
   always_comb begin
      probe_hit   = 1'b0;
      probe_score = '0;
      if (rd_ff.key == key_ff && rd_ff.depth >= depth_ff) begin
         case (rd_ff.bound)
            BOUND_EXACT: begin
               probe_hit   = 1'b1;
               probe_score = rd_ff.score;
            end
            BOUND_UPPER: begin
               if (rd_ff.score <= alpha_ff) begin
                  probe_hit   = 1'b1;
                  probe_score = alpha_ff;
               end
            end
            BOUND_LOWER: begin
               if (rd_ff.score >= beta_ff) begin
                  probe_hit   = 1'b1;
                  probe_score = beta_ff;
               end
            end
            default: begin
               probe_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_PROBE || req_command == CMD_RECORD) begin
                  state_in = ST_REDUCE;
               end else if (req_command == CMD_CLEAR) begin
                  state_in = ST_WIPE;
               end
            end
         end
         ST_REDUCE: begin
            if (reduce_done) begin
               state_in = (cmd_ff == CMD_PROBE) ? ST_DECIDE : ST_IDLE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         ST_WIPE: begin
            if (wipe_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_score_in = '0;
      mem_we       = 1'b0;
      mem_waddr    = slot;
      mem_wdata    = '{key: key_ff, depth: depth_ff, bound: kind_ff, score: score_ff};
      mem_re       = 1'b0;
      wipe_in      = wipe_ff;
      wipe_rsp_in  = wipe_rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            wipe_in = '0;
            if (accept) begin
               if (req_command == CMD_CLEAR) begin
                  wipe_rsp_in = 1'b1;
               end else if (req_command != CMD_PROBE && req_command != CMD_RECORD) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            if (reduce_done) begin
               if (cmd_ff == CMD_PROBE) begin
                  mem_re = 1'b1;
               end else begin
                  mem_we       = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = probe_hit;
            rsp_score_in = probe_score;
         end
         ST_WIPE: begin
            mem_we    = 1'b1;
            mem_waddr = wipe_ff;
            mem_wdata = '0;
            wipe_in   = wipe_ff + 1'b1;
            if (wipe_ff == LAST_SLOT) begin
               // reset pass gives no result, a clear request does
               rsp_valid_in = wipe_rsp_ff;
               wipe_rsp_in  = 1'b0;
               wipe_in      = '0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_score = rsp_score_ff;

endmodule

### bench/bounded_score_transposition_table_unit_test.sv
`timescale 1ns / 1ps

module bounded_score_transposition_table_unit_test;
   import bstt_pkg::*;

   localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
   localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 21'sd1000000;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = -21'sd1000000;
   localparam logic signed [SCORE_W-1:0] WIDE_MAX  = 21'h0FFFFF;
   localparam logic signed [SCORE_W-1:0] WIDE_MIN  = 21'h100000;

   localparam logic [KEY_W-1:0] K_ALL   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [KEY_W-1:0] K_ALIAS = 64'h0000_0000_0000_0FFF;
   localparam logic [KEY_W-1:0] K_UP    = 64'h8000_0000_0000_0001;
   localparam logic [KEY_W-1:0] K_LO    = 64'h0123_4567_89AB_CDEF;
   localparam logic [KEY_W-1:0] K_ODD   = 64'h5555_AAAA_5555_A002;
   localparam logic [KEY_W-1:0] K_NEG   = 64'h2AAA_5555_AAAA_5003;

   localparam int RANDOM_REQUESTS = 1400;
   localparam int CALM_TAIL       = 200;
   localparam int CLEAR_CAP       = 16;
   localparam int POOL_SIZE       = 16;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic [KEY_W-1:0]          key;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
      logic signed [SCORE_W-1:0] score;
      logic [BOUND_W-1:0]        kind;
   } request_type;

   typedef struct {
      logic                      hit;
      logic signed [SCORE_W-1:0] score;
   } answer_type;

   class shadow_table;
      logic [KEY_W-1:0]          stored_key   [TABLE_ENTRIES_DEFAULT];
      logic [DEPTH_W-1:0]        stored_depth [TABLE_ENTRIES_DEFAULT];
      logic [BOUND_W-1:0]        stored_bound [TABLE_ENTRIES_DEFAULT];
      logic signed [SCORE_W-1:0] stored_score [TABLE_ENTRIES_DEFAULT];
      answer_type answers_due[$];
      int mismatches;
      int probes;
      int records;
      int clears;
      int hits;

      function new();
         wipe();
         mismatches = 0;
         probes = 0;
         records = 0;
         clears = 0;
         hits = 0;
      endfunction

      function void wipe();
         for (int i = 0; i < TABLE_ENTRIES_DEFAULT; i++) begin
            stored_key[i]   = '0;
            stored_depth[i] = '0;
            stored_bound[i] = BOUND_EXACT;
            stored_score[i] = '0;
         end
      endfunction

      function void apply_request(request_type r);
         int unsigned slot;
         answer_type a;
         slot = int'(r.key % TABLE_ENTRIES_DEFAULT);
         a.hit = 1'b0;
         a.score = '0;
         case (r.command)
            CMD_PROBE: begin
               probes++;
               if (stored_key[slot] == r.key && stored_depth[slot] >= r.depth) begin
                  case (stored_bound[slot])
                     BOUND_EXACT: begin
                        a.hit = 1'b1;
                        a.score = stored_score[slot];
                     end
                     BOUND_UPPER: begin
                        if (stored_score[slot] <= r.alpha) begin
                           a.hit = 1'b1;
                           a.score = r.alpha;
                        end
                     end
                     BOUND_LOWER: begin
                        if (stored_score[slot] >= r.beta) begin
                           a.hit = 1'b1;
                           a.score = r.beta;
                        end
                     end
                     default: ;
                  endcase
               end
               if (a.hit) hits++;
            end
            CMD_RECORD: begin
               records++;
               stored_key[slot]   = r.key;
               stored_depth[slot] = r.depth;
               stored_bound[slot] = r.kind;
               stored_score[slot] = r.score;
            end
            CMD_CLEAR: begin
               clears++;
               wipe();
            end
            default: ;
         endcase
         answers_due.push_back(a);
      endfunction

      task report_mismatch(string what, logic signed [SCORE_W-1:0] got,
                           logic signed [SCORE_W-1:0] want);
         mismatches++;
         $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
      endtask

      task check_answer(logic hit, logic signed [SCORE_W-1:0] score);
         answer_type want;
         if (answers_due.size() == 0) begin
            report_mismatch("result with no request pending", score, '0);
            return;
         end
         want = answers_due.pop_front();
         if (hit !== want.hit) report_mismatch("hit", {20'b0, hit}, {20'b0, want.hit});
         if (score !== want.score) report_mismatch("score", score, want.score);
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CMD_W-1:0]          req_command;
   logic [KEY_W-1:0]          req_position_key;
   logic [DEPTH_W-1:0]        req_search_depth;
   logic signed [SCORE_W-1:0] req_alpha_bound;
   logic signed [SCORE_W-1:0] req_beta_bound;
   logic signed [SCORE_W-1:0] req_new_score;
   logic [BOUND_W-1:0]        req_new_bound_kind;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic signed [SCORE_W-1:0] rsp_score;

   shadow_table table_copy = new();
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int clears_sent = 0;

   bounded_score_transposition_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_position_key   (req_position_key),
      .req_search_depth   (req_search_depth),
      .req_alpha_bound    (req_alpha_bound),
      .req_beta_bound     (req_beta_bound),
      .req_new_score      (req_new_score),
      .req_new_bound_kind (req_new_bound_kind),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_score          (rsp_score)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("bounded_score_transposition_table_unit_test NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) table_copy.check_answer(rsp_hit, rsp_score);
   end

   function automatic request_type mk(logic [CMD_W-1:0] command, logic [KEY_W-1:0] key,
                                      logic [DEPTH_W-1:0] depth,
                                      logic signed [SCORE_W-1:0] alpha,
                                      logic signed [SCORE_W-1:0] beta,
                                      logic signed [SCORE_W-1:0] score,
                                      logic [BOUND_W-1:0] kind);
      request_type r;
      r.command = command;
      r.key = key;
      r.depth = depth;
      r.alpha = alpha;
      r.beta = beta;
      r.score = score;
      r.kind = kind;
      return r;
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      int v;
      case ($urandom_range(0, 9))
         0: return SCORE_MIN;
         1: return SCORE_MAX;
         2: return SCORE_W'($urandom);
         default: begin
            v = int'($urandom_range(0, 2000000)) - 1000000;
            return SCORE_W'(v);
         end
      endcase
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth();
      if ($urandom_range(0, 1) == 0) return DEPTH_W'($urandom_range(0, 15));
      return DEPTH_W'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 5);
      return 0;
   endfunction

   // mostly pool keys so probes find recorded entries; noise uses any key and any code
   function automatic request_type make_random(bit noise);
      request_type r;
      int roll;
      r = mk(CMD_PROBE, key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_depth(),
             pick_score(), pick_score(), pick_score(), BOUND_W'($urandom_range(0, 2)));
      roll = $urandom_range(0, 99);
      if (noise) begin
         r.key = {$urandom, $urandom};
         r.command = CMD_W'($urandom_range(0, 3));
         r.kind = BOUND_W'($urandom_range(0, 3));
      end else if (roll < 55) begin
         r.command = CMD_PROBE;
      end else if (roll < 98) begin
         r.command = CMD_RECORD;
      end else begin
         r.command = CMD_CLEAR;
      end
      if (r.command == CMD_CLEAR && clears_sent >= CLEAR_CAP) r.command = CMD_PROBE;
      return r;
   endfunction

   task automatic send_request(request_type r, int idle_after);
      @(negedge clock);
      start = 1'b1;
      req_command = r.command;
      req_position_key = r.key;
      req_search_depth = r.depth;
      req_alpha_bound = r.alpha;
      req_beta_bound = r.beta;
      req_new_score = r.score;
      req_new_bound_kind = r.kind;
      do @(posedge clock); while (busy);
      table_copy.apply_request(r);
      if (r.command == CMD_CLEAR) clears_sent++;
      if (idle_after > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (idle_after - 1) @(negedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_PROBE;
      req_position_key = '0;
      req_search_depth = '0;
      req_alpha_bound = '0;
      req_beta_bound = '0;
      req_new_score = '0;
      req_new_bound_kind = BOUND_EXACT;

      // key zero, colliding keys sharing one slot, the rest spread
      key_pool[0] = '0;
      for (int i = 1; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      for (int i = 1; i < 4; i++) key_pool[i][11:0] = key_pool[4][11:0];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // cleared entries hold key zero at depth zero
      send_request(mk(CMD_PROBE, '0, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, '0, 8'd1, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_RECORD, K_ALL, 8'd255, '0, '0, SCORE_MAX, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_ALL, 8'd255, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_ALIAS, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_RECORD, K_UP, 8'd0, '0, '0, SCORE_MIN, BOUND_UPPER), pick_gap());
      send_request(mk(CMD_PROBE, K_UP, 8'd0, SCORE_MIN, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_UP, 8'd0, WIDE_MIN, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_UP, 8'd1, SCORE_MAX, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_RECORD, K_LO, 8'd40, '0, '0, SCORE_MAX, BOUND_LOWER), pick_gap());
      send_request(mk(CMD_PROBE, K_LO, 8'd40, '0, SCORE_MAX, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_LO, 8'd40, '0, WIDE_MAX, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_LO, 8'd0, '0, WIDE_MIN, '0, BOUND_EXACT), pick_gap());
      // unused bound kind is stored but never hits
      send_request(mk(CMD_RECORD, K_ODD, 8'd255, '0, '0, '0, BOUND_UNUSED), pick_gap());
      send_request(mk(CMD_PROBE, K_ODD, 8'd0, WIDE_MAX, WIDE_MIN, '0, BOUND_EXACT),
                   pick_gap());
      send_request(mk(CMD_UNUSED, K_ALL, 8'd0, WIDE_MAX, WIDE_MAX, WIDE_MIN, BOUND_UNUSED),
                   pick_gap());
      send_request(mk(CMD_PROBE, K_ALL, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_RECORD, K_NEG, 8'd7, '0, '0, WIDE_MIN, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_NEG, 8'd7, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_CLEAR, '0, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, K_ALL, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());
      send_request(mk(CMD_PROBE, '0, 8'd0, '0, '0, '0, BOUND_EXACT), pick_gap());

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         send_request(make_random($urandom_range(0, 99) < 15),
                      (n < RANDOM_REQUESTS - CALM_TAIL) ? pick_gap() : 0);
      end

      @(negedge clock);
      start = 1'b0;
      while (table_copy.answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d probes (%0d hits), %0d records and %0d clears",
               table_copy.probes, table_copy.hits, table_copy.records, table_copy.clears);
      $display("including cleared key zero, slot aliasing, unused codes and window extremes");
      if (table_copy.mismatches == 0) begin
         $display("bounded_score_transposition_table_unit_test OK");
      end else begin
         $display("bounded_score_transposition_table_unit_test NOT OK");
      end
      $finish;
   end

endmodule
